// ----- hdl/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Controller states, command/status structs and default sizes.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int unsigned DefaultEntries = 64;
   localparam int unsigned CapWidth       = 7;
   localparam int unsigned KeyWidth       = 32;
   localparam int unsigned ValueWidth     = 32;
   localparam int unsigned CountWidth     = 32;
   localparam int unsigned StampWidth     = 64;

   localparam logic [CapWidth-1:0] CapReset = 7'd64;

   localparam logic KindRead  = 1'b0;
   localparam logic KindWrite = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_COMMIT,
      ST_RESPOND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, clear scan results
      logic scan_step;  // examine one slot
      logic commit;     // apply update at the chosen slot
      logic respond;    // drive response strobe
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;  // the slot being examined is the last one
   } sts_type;

endpackage : lfu_pkg
`default_nettype wire

// ----- hdl/lfu_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_datapath: entry storage and scan logic
// Holds the table, walks one slot per cycle for match, victim and free slot.
// ----------------------------------------------------------------------------
module lfu_datapath
   import lfu_pkg::*;
#(
   parameter int unsigned ENTRIES = DefaultEntries
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [CapWidth-1:0]   capacity_in_use,
   input  wire logic                  req_kind,
   input  wire logic [KeyWidth-1:0]   req_key,
   input  wire logic [ValueWidth-1:0] req_write_value,
   output logic                       rsp_hit,
   output logic [ValueWidth-1:0]      rsp_read_value,
   output logic                       rsp_evicted
);

   localparam int unsigned IdxWidth = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned OccWidth = $clog2(ENTRIES + 1);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(ENTRIES - 1);

   // memories: one read address per cycle, registered read data
   logic [KeyWidth-1:0]   key_mem   [ENTRIES];
   logic [ValueWidth-1:0] value_mem [ENTRIES];
   logic [CountWidth-1:0] count_mem [ENTRIES];
   logic [StampWidth-1:0] stamp_mem [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;

   logic [IdxWidth-1:0]   rd_idx_ff, rd_idx_in;   // slot being fetched
   logic                  rd_vld_ff;              // fetched data is for a scan
   logic [IdxWidth-1:0]   cur_idx_ff;             // slot of fetched data
   logic [KeyWidth-1:0]   rd_key_ff;
   logic [ValueWidth-1:0] rd_value_ff;
   logic [CountWidth-1:0] rd_count_ff;
   logic [StampWidth-1:0] rd_stamp_ff;

   logic                  kind_ff;
   logic [KeyWidth-1:0]   key_ff;
   logic [ValueWidth-1:0] wval_ff;

   logic                  hit_ff;
   logic [IdxWidth-1:0]   hit_idx_ff;
   logic [ValueWidth-1:0] hit_value_ff;
   logic [CountWidth-1:0] hit_count_ff;
   logic                  vic_have_ff;
   logic [IdxWidth-1:0]   vic_idx_ff;
   logic [CountWidth-1:0] vic_count_ff;
   logic [StampWidth-1:0] vic_stamp_ff;
   logic                  free_have_ff;
   logic [IdxWidth-1:0]   free_idx_ff;

   logic [StampWidth-1:0] seq_ff;
   logic [OccWidth-1:0]   occ_ff;

   logic                  rsp_hit_ff;
   logic [ValueWidth-1:0] rsp_value_ff;
   logic                  rsp_evicted_ff;

   logic [OccWidth-1:0]   eff_cap;
   logic                  cur_valid;
   logic                  full;
   logic                  do_insert;
   logic                  do_evict;
   logic [IdxWidth-1:0]   ins_idx;
   logic [CountWidth-1:0] hit_count_inc;

   always_comb begin
      if (capacity_in_use == '0) begin
         eff_cap = OccWidth'(1);
      end else if (32'(capacity_in_use) > ENTRIES) begin
         eff_cap = OccWidth'(ENTRIES);
      end else begin
         eff_cap = OccWidth'(capacity_in_use);
      end
   end

   assign cur_valid = valid_ff[cur_idx_ff];
   assign full      = occ_ff >= eff_cap;
   assign do_evict  = !hit_ff && kind_ff && full && vic_have_ff;
   assign do_insert = !hit_ff && kind_ff && (do_evict || free_have_ff);
   assign ins_idx   = do_evict ? vic_idx_ff : free_idx_ff;
   assign hit_count_inc = (hit_count_ff == '1) ? hit_count_ff : hit_count_ff + 1'b1;

   assign sts.scan_last = rd_vld_ff && (cur_idx_ff == LastIdx);

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
      end else if (cmd.scan_step && rd_idx_ff != LastIdx) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   // memory read port and writes
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_idx_ff];
      rd_value_ff <= value_mem[rd_idx_ff];
      rd_count_ff <= count_mem[rd_idx_ff];
      rd_stamp_ff <= stamp_mem[rd_idx_ff];
      cur_idx_ff  <= rd_idx_ff;
      rd_idx_ff   <= rd_idx_in;
      if (cmd.commit) begin
         if (hit_ff) begin
            if (kind_ff == KindWrite) begin
               value_mem[hit_idx_ff] <= wval_ff;
            end
            count_mem[hit_idx_ff] <= hit_count_inc;
            stamp_mem[hit_idx_ff] <= seq_ff;
         end else if (do_insert) begin
            key_mem[ins_idx]   <= key_ff;
            value_mem[ins_idx] <= wval_ff;
            count_mem[ins_idx] <= CountWidth'(1);
            stamp_mem[ins_idx] <= seq_ff;
         end
      end
   end

   // request capture and scan results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         wval_ff <= req_write_value;
      end
      if (cmd.scan_step && rd_vld_ff && cur_valid) begin
         if (!hit_ff && rd_key_ff == key_ff) begin
            hit_idx_ff   <= cur_idx_ff;
            hit_value_ff <= rd_value_ff;
            hit_count_ff <= rd_count_ff;
         end
         if (!vic_have_ff || rd_count_ff < vic_count_ff ||
             (rd_count_ff == vic_count_ff && rd_stamp_ff < vic_stamp_ff)) begin
            vic_idx_ff   <= cur_idx_ff;
            vic_count_ff <= rd_count_ff;
            vic_stamp_ff <= rd_stamp_ff;
         end
      end
      if (cmd.scan_step && rd_vld_ff && !cur_valid && !free_have_ff) begin
         free_idx_ff <= cur_idx_ff;
      end
      if (cmd.commit) begin
         rsp_hit_ff     <= hit_ff;
         rsp_value_ff   <= (hit_ff && kind_ff == KindRead) ? hit_value_ff : '0;
         rsp_evicted_ff <= do_evict;
      end
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         seq_ff       <= '0;
         occ_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         vic_have_ff  <= 1'b0;
         free_have_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rd_vld_ff    <= 1'b0;
            hit_ff       <= 1'b0;
            vic_have_ff  <= 1'b0;
            free_have_ff <= 1'b0;
         end else begin
            rd_vld_ff <= cmd.scan_step && !(rd_vld_ff && cur_idx_ff == LastIdx);
            if (cmd.scan_step && rd_vld_ff) begin
               if (cur_valid && rd_key_ff == key_ff) begin
                  hit_ff <= 1'b1;
               end
               if (cur_valid) begin
                  vic_have_ff <= 1'b1;
               end else begin
                  free_have_ff <= 1'b1;
               end
            end
         end
         if (cmd.commit) begin
            if (hit_ff || do_insert) begin
               seq_ff <= seq_ff + 1'b1;
            end
            if (do_insert) begin
               valid_ff[ins_idx] <= 1'b1;
               if (!do_evict) begin
                  occ_ff <= occ_ff + 1'b1;
               end
            end
         end
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule : lfu_datapath
`default_nettype wire

// ----- hdl/lfu_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_control: request sequencer
// Walks load, slot scan, commit and response for one transaction at a time.
// ----------------------------------------------------------------------------
module lfu_control
   import lfu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // scan results settle; victim/free chosen
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            rsp_valid   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : lfu_control
`default_nettype wire

// ----- hdl/lfu_cache_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with LFU replacement, LRU tie-break
// Controller plus datapath; one transaction scans every slot in turn.
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   req_kind, req_key, req_write_value      start & !busy
// response  rsp_hit, rsp_read_value, rsp_evicted    rsp_valid, one cycle
// config    csr_write_enable, csr_write_data        csr_write_enable
//
// A transaction runs from accept to response strobe as a scan of one slot
// per cycle through the single memory read port, then decide, commit and
// respond. busy is high throughout.
// Synchronous reset clears the valid bits, occupancy and access stamp.
// The receiver cannot stall; the response strobe is present for one cycle only.
// ----------------------------------------------------------------------------
module lfu_cache_table
   import lfu_pkg::*;
#(
   parameter int unsigned ENTRIES = DefaultEntries
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_kind,
   input  wire logic [KeyWidth-1:0]   req_key,
   input  wire logic [ValueWidth-1:0] req_write_value,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [ValueWidth-1:0]      rsp_read_value,
   output logic                       rsp_evicted,
   input  wire logic                  csr_write_enable,
   input  wire logic [CapWidth-1:0]   csr_write_data
);

   cmd_type cmd;
   sts_type sts;
   logic [CapWidth-1:0] capacity_ff;

   // capacity register; clamping happens in the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapReset;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   lfu_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lfu_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .capacity_in_use (capacity_ff),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted)
   );

endmodule : lfu_cache_table
`default_nettype wire

// ----- hdl/lfu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_checker: port-level checks for the LFU cache table
// Watches handshake and response ports; bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_hit,
   input wire logic        rsp_evicted,
   input wire logic [31:0] rsp_read_value
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a transaction");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("eviction reported on a hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == 32'd0))
      else $error("nonzero read value on a miss");

endmodule : lfu_checker

bind lfu_cache_table lfu_checker u_lfu_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_evicted    (rsp_evicted),
   .rsp_read_value (rsp_read_value)
);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LFU cache table
// Drives read/write transactions, predicts each response with a local model
// of the cache (LFU victim, oldest stamp among equal counts) and compares.
// ----------------------------------------------------------------------------
module testbench;
   import lfu_pkg::*;

   localparam int Slots = 64;
   localparam int CycleLimit = 900000;

   typedef struct packed {
      logic                  kind;
      logic [KeyWidth-1:0]   key;
      logic [ValueWidth-1:0] wval;
   } lookup_type;

   typedef struct packed {
      logic                  hit;
      logic [ValueWidth-1:0] rval;
      logic                  evicted;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [KeyWidth-1:0] req_key = '0;
   logic [ValueWidth-1:0] req_write_value = '0;
   logic rsp_valid, rsp_hit, rsp_evicted;
   logic [ValueWidth-1:0] rsp_read_value;
   logic csr_write_enable = 1'b0;
   logic [CapWidth-1:0] csr_write_data = '0;

   lfu_cache_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key(req_key), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_evicted(rsp_evicted),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // cache shadow
   logic [CapWidth-1:0]   cap_reg;
   logic                  sh_valid [Slots];
   logic [KeyWidth-1:0]   sh_key   [Slots];
   logic [ValueWidth-1:0] sh_value [Slots];
   logic [CountWidth-1:0] sh_count [Slots];
   logic [StampWidth-1:0] sh_stamp [Slots];
   logic [StampWidth-1:0] seq_now;
   int                    fill;

   lookup_type pending_lookups[$];
   answer_type expected_answers[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  sender_idle_pct = 29;
   bit  hold_sender = 1'b0;
   bit  stimulus_done = 1'b0;

   function automatic void shadow_reset();
      cap_reg = CapReset;
      for (int i = 0; i < Slots; i++) sh_valid[i] = 1'b0;
      seq_now = '0;
      fill = 0;
   endfunction

   function automatic void bump(int s);
      if (sh_count[s] != '1) sh_count[s] = sh_count[s] + 1;
      sh_stamp[s] = seq_now;
      seq_now = seq_now + 1;
   endfunction

   // compute the expected response and update the shadow
   function automatic answer_type lookup_cache(lookup_type t);
      answer_type a;
      int found, slot, limit;
      bit have;
      a = '0;
      found = -1;
      for (int i = 0; i < Slots; i++)
         if (found < 0 && sh_valid[i] && sh_key[i] == t.key) found = i;
      if (found >= 0) begin
         a.hit = 1'b1;
         if (t.kind == KindRead) a.rval = sh_value[found];
         else sh_value[found] = t.wval;
         bump(found);
      end else if (t.kind == KindWrite) begin
         limit = (cap_reg == 0) ? 1 : (cap_reg > Slots ? Slots : int'(cap_reg));
         have = 1'b0;
         slot = 0;
         if (fill >= limit) begin
            for (int i = 0; i < Slots; i++) begin
               if (sh_valid[i] && (!have || sh_count[i] < sh_count[slot] ||
                   (sh_count[i] == sh_count[slot] && sh_stamp[i] < sh_stamp[slot]))) begin
                  slot = i;
                  have = 1'b1;
               end
            end
            if (have) begin
               sh_valid[slot] = 1'b0;
               fill--;
               a.evicted = 1'b1;
            end
         end
         if (!have)
            for (int i = Slots - 1; i >= 0; i--)
               if (!sh_valid[i]) begin
                  slot = i;
                  have = 1'b1;
               end
         sh_valid[slot] = 1'b1;
         sh_key[slot] = t.key;
         sh_value[slot] = t.wval;
         sh_count[slot] = '0;
         bump(slot);
         fill++;
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver: advance one transaction per accept, idle at random
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            pending_lookups.delete(0);
         end
         if ((start && !busy) || !start) begin
            if (pending_lookups.size() > 0 && !hold_sender &&
                $urandom_range(99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_kind <= pending_lookups[0].kind;
               req_key <= pending_lookups[0].key;
               req_write_value <= pending_lookups[0].wval;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // prediction happens at accept so config ordering stays exact
   always @(posedge clock) begin
      if (!reset && start && !busy)
         expected_answers.push_back(lookup_cache('{req_kind, req_key, req_write_value}));
   end

   // monitor: compare each strobe against the oldest expectation
   always @(posedge clock) begin
      answer_type want;
      cycle_count++;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected response", 64'd0, 64'd0);
         end else begin
            want = expected_answers[0];
            expected_answers.delete(0);
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_read_value !== want.rval)
               report_mismatch("read_value", rsp_read_value, want.rval);
            if (rsp_evicted !== want.evicted)
               report_mismatch("evicted", rsp_evicted, want.evicted);
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // the driver reads the queue head; append only, never pop here
   task automatic queue_lookup(input logic kind, input logic [31:0] key,
                               input logic [31:0] wval);
      pending_lookups.push_back('{kind, key, wval});
   endtask

   // wait for every queued transaction to be accepted and answered
   task automatic drain();
      while (pending_lookups.size() > 0 || start || busy || expected_answers.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CapWidth-1:0] cap);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      cap_reg = cap;
      csr_write_enable <= 1'b0;
   endtask

   // random traffic over a small key pool so hits and evictions are common
   task automatic random_phase(input int count, input int pool);
      logic [31:0] k;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) k = $urandom();
         else k = $urandom_range(pool - 1) ^ 32'hA5A5_0000;
         queue_lookup($urandom_range(1), k, $urandom());
      end
   endtask

   initial begin
      shadow_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme keys and values, read miss, write miss, hits
      queue_lookup(KindRead, 32'h0, 32'hFFFF_FFFF);
      queue_lookup(KindWrite, 32'h0, 32'hFFFF_FFFF);
      queue_lookup(KindWrite, 32'hFFFF_FFFF, 32'h0);
      queue_lookup(KindRead, 32'h0, 32'h0);
      queue_lookup(KindRead, 32'hFFFF_FFFF, 32'h1234_5678);
      queue_lookup(KindWrite, 32'h0, 32'h5555_AAAA);
      queue_lookup(KindRead, 32'h0, 32'h0);
      drain();
      // capacity zero acts as one: each new write evicts
      write_capacity(7'd0);
      for (int i = 0; i < 4; i++) queue_lookup(KindWrite, 32'h100 + i, 32'hAAAA_5555 + i);
      queue_lookup(KindRead, 32'h103, 0);
      drain();
      // capacity above table size; fill past 64 entries
      write_capacity(7'd127);
      for (int i = 0; i < 70; i++) queue_lookup(KindWrite, 32'h200 + i, i);
      drain();
      // lower capacity below occupancy, with hits to skew counts
      write_capacity(7'd3);
      queue_lookup(KindRead, 32'h230, 0);
      queue_lookup(KindWrite, 32'h231, 7);
      for (int i = 0; i < 5; i++) queue_lookup(KindWrite, 32'h300 + i, i);
      drain();

      // random phases: sender idles, then not; several capacities
      sender_idle_pct = 29;
      write_capacity(7'd8);
      random_phase(300, 24);
      drain();
      write_capacity(7'd64);
      sender_idle_pct = 85;
      random_phase(200, 96);
      // hold off until everything in flight has been answered
      hold_sender = 1'b1;
      while (busy || start || expected_answers.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      drain();
      write_capacity(7'd1);
      sender_idle_pct = 0;
      random_phase(150, 6);
      drain();
      write_capacity(7'd40);
      random_phase(200, 64);
      drain();

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
